// ----- hdl/swhs_pkg.sv -----
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared widths, constants, register indexes and types for the single-wire
// humidity sensor frame decoder.
// ----------------------------------------------------------------------------
package swhs_pkg;

  localparam int unsigned TICK_W    = 8;   // interval tick counter
  localparam int unsigned IDX_W     = 7;   // interval index
  localparam int unsigned BITS_W    = 6;   // recognized data bit count
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAME_W   = 40;  // five bytes of frame
  localparam int unsigned WORD_W    = 16;  // humidity / temperature words

  localparam int unsigned MAX_INTERVALS       = 90;
  localparam int unsigned FIRST_DATA_INTERVAL = 4;
  localparam int unsigned FRAME_BITS          = 40;
  localparam int unsigned BITS_SAT            = 63;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  localparam logic [CFG_DATA_W-1:0] BIT_THRESHOLD_RST = 8'd40;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_TICKS_RST = 8'd255;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_CHECKSUM = 2'd2
  } status_e;

  // Tracker -> formatter: end-of-read flag and the frame as it stands
  typedef struct packed {
    logic                 done;
    logic [BITS_W-1:0]    bits;
    logic [FRAME_W-1:0]   frame;
  } track_t;

  typedef struct packed {
    status_e              status;
    logic [WORD_W-1:0]    humidity;
    logic [WORD_W-1:0]    temperature;
    logic [BITS_W-1:0]    bits;
  } result_t;

endpackage

// ----- hdl/swhs_tracker.sv -----
// ----------------------------------------------------------------------------
// swhs_tracker
// Interval timing state: measures line level run lengths, shifts in data
// bits and flags the tick that ends a read.
// ----------------------------------------------------------------------------
module swhs_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          start_i,
  input  logic                          level_i,
  input  logic [swhs_pkg::TICK_W-1:0]   threshold_i,
  input  logic [swhs_pkg::TICK_W-1:0]   timeout_i,
  output swhs_pkg::track_t              track_o
);
  import swhs_pkg::*;

  logic                 reading_q, reading_d;
  logic                 prev_q, prev_d;
  logic [TICK_W-1:0]    ticks_q, ticks_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [BITS_W-1:0]    bits_q, bits_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic                 done;
  logic                 data_interval;

  assign data_interval = (idx_q >= IDX_W'(FIRST_DATA_INTERVAL)) && !idx_q[0];

  always_comb begin
    reading_d = reading_q;
    prev_d    = prev_q;
    ticks_d   = ticks_q;
    idx_d     = idx_q;
    bits_d    = bits_q;
    frame_d   = frame_q;
    done      = 1'b0;
    if (en_i) begin
      if (start_i) begin
        reading_d = 1'b1;
        prev_d    = 1'b1;
        ticks_d   = '0;
        idx_d     = '0;
        bits_d    = '0;
        frame_d   = '0;
      end else if (reading_q) begin
        if (level_i != prev_q) begin
          // level change closes the running interval
          if (data_interval) begin
            if (bits_q < BITS_W'(FRAME_BITS)) begin
              frame_d = {frame_q[FRAME_W-2:0], (ticks_q > threshold_i)};
            end
            if (bits_q < BITS_W'(BITS_SAT)) begin
              bits_d = bits_q + BITS_W'(1);
            end
          end
          idx_d = idx_q + IDX_W'(1);
          if (idx_d >= IDX_W'(MAX_INTERVALS)) begin
            done = 1'b1;
          end else begin
            prev_d  = level_i;
            ticks_d = TICK_W'(1);
            done    = (ticks_d >= timeout_i);
          end
        end else begin
          ticks_d = ticks_q + TICK_W'(1);
          done    = (ticks_d >= timeout_i);
        end
        if (done) begin
          reading_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reading_q <= 1'b0;
      prev_q    <= 1'b1;
      ticks_q   <= '0;
      idx_q     <= '0;
      bits_q    <= '0;
      frame_q   <= '0;
    end else begin
      reading_q <= reading_d;
      prev_q    <= prev_d;
      ticks_q   <= ticks_d;
      idx_q     <= idx_d;
      bits_q    <= bits_d;
      frame_q   <= frame_d;
    end
  end

  assign track_o.done  = done;
  assign track_o.bits  = bits_d;
  assign track_o.frame = frame_d;

endmodule

// ----- hdl/swhs_formatter.sv -----
// ----------------------------------------------------------------------------
// swhs_formatter
// Checks bit count and checksum of a finished frame and unpacks humidity
// and sign-magnitude temperature.
// ----------------------------------------------------------------------------
module swhs_formatter (
  input  swhs_pkg::track_t   track_i,
  output swhs_pkg::result_t  result_o
);
  import swhs_pkg::*;

  logic [BYTE_W-1:0]   b0, b1, b2, b3, b4;
  logic [BYTE_W-1:0]   sum;
  logic [WORD_W-1:0]   magnitude;

  assign b0 = track_i.frame[4*BYTE_W +: BYTE_W];
  assign b1 = track_i.frame[3*BYTE_W +: BYTE_W];
  assign b2 = track_i.frame[2*BYTE_W +: BYTE_W];
  assign b3 = track_i.frame[1*BYTE_W +: BYTE_W];
  assign b4 = track_i.frame[0       +: BYTE_W];

  assign sum       = b0 + b1 + b2 + b3;  // modulo 256
  assign magnitude = {1'b0, b2[BYTE_W-2:0], b3};

  always_comb begin
    result_o.bits        = track_i.bits;
    result_o.humidity    = '0;
    result_o.temperature = '0;
    if (track_i.bits < BITS_W'(FRAME_BITS)) begin
      result_o.status = ST_SHORT;
    end else if (sum != b4) begin
      result_o.status = ST_CHECKSUM;
    end else begin
      result_o.status   = ST_OK;
      result_o.humidity = {b0, b1};
      // sign bit of byte 2; negating zero still gives zero
      result_o.temperature = b2[BYTE_W-1] ? (WORD_W'(0) - magnitude) : magnitude;
    end
  end

endmodule

// ----- hdl/single_wire_humidity_sensor_decoder.sv -----
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_decoder
// Decodes the bit stream of a single-wire humidity/temperature sensor from
// one sampled line level per microsecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per tick. tuser = start_req (1 starts a new read
//   and clears the decoder; that tick's level is not counted), tdata[0] =
//   line level. Ticks arriving while no read runs are dropped silently.
//   Master stream: one item per finished read (interval limit reached or an
//   interval hit the timeout). tuser = status (0 ok, 1 short, 2 checksum),
//   tdata = humidity, temperature (signed), bit count.
//   Config port: write-only, index 0 = bit threshold, 1 = timeout ticks;
//   other indexes are ignored. Write only while the decoder is idle.
// Timing:
//   1 item per cycle sustained while the result stream does not stall. An
//   item lands in the input register on the accepting edge; when the pipe
//   can move, the tracker updates from it and any result of the item that
//   ends the read is captured in the output register, which then offers it.
//   When the receiver stalls with a result pending, the input register still
//   takes one item; further items wait until the result is taken.
// Reset:
//   Idle, line assumed high, counters and frame cleared, threshold 40,
//   timeout 255, both registers empty.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_decoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [swhs_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [0] line_level
  input  logic                                 s_axis_tuser,  // [0] start_req
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [15:0] humidity_tenths, [31:16] temperature_tenths, [37:32] bit_count
  output logic [swhs_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,  // [1:0] status
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [swhs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [swhs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import swhs_pkg::*;

  // config registers
  logic [CFG_DATA_W-1:0] threshold_q, timeout_q;

  // input register
  logic       in_valid_q, in_valid_d;
  logic       in_start_q, in_level_q;

  // output register
  logic       out_valid_q, out_valid_d;
  result_t    out_q;

  logic       advance;   // output slot free or draining: a held input item moves into the tracker this cycle
  logic       en;
  track_t     track;
  result_t    result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= BIT_THRESHOLD_RST;
      timeout_q   <= TIMEOUT_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BIT_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_TIMEOUT_TICKS: timeout_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output slot free or draining this cycle: the pipe can move.
  assign advance       = !out_valid_q || m_axis_tready;
  assign en            = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_valid_d    = s_axis_tready ? s_axis_tvalid : in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_start_q <= s_axis_tuser;
      in_level_q <= s_axis_tdata[0];
    end
  end

  swhs_tracker u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .start_i     (in_start_q),
    .level_i     (in_level_q),
    .threshold_i (threshold_q),
    .timeout_i   (timeout_q),
    .track_o     (track)
  );

  swhs_formatter u_formatter (
    .track_i  (track),
    .result_o (result)
  );

  assign out_valid_d = advance ? (en && track.done) : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && track.done) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {(OUT_TDATA_W - 2*WORD_W - BITS_W)'(0), out_q.bits,
                          out_q.temperature, out_q.humidity};

endmodule
